[hw/rtl/rtn_pkg.sv]
// ----------------------------------------------------------------------------
// rtn_pkg
// Shared types and constants of the ring-tone text note parser: widths, limits
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rtn_pkg;

    localparam int CHAR_W  = 8;
    localparam int NUM_W   = 14;
    localparam int DDUR_W  = 8;
    localparam int DOCT_W  = 3;
    localparam int SHIFT_W = 3;
    localparam int WHOLE_W = 18;
    localparam int DUR_W   = 19;
    localparam int PITCH_W = 6;
    localparam int OCT_W   = 4;

    // Divider operand widths: dividend is the whole-note time or milliseconds per minute, divisor a number field.
    localparam int DVD_W = WHOLE_W;
    localparam int DVS_W = NUM_W;

    localparam logic [NUM_W-1:0]   NUM_MAX      = NUM_W'(9999);
    localparam logic [DDUR_W-1:0]  DDUR_MAX     = DDUR_W'(255);
    localparam logic [DVD_W-1:0]   MS_PER_MIN   = DVD_W'(60000);
    localparam logic [DDUR_W-1:0]  DDUR_RESET   = DDUR_W'(4);
    localparam logic [DOCT_W-1:0]  DOCT_RESET   = DOCT_W'(6);
    localparam logic [NUM_W-1:0]   TEMPO_RESET  = NUM_W'(63);
    localparam logic [WHOLE_W-1:0] WHOLE_RESET  = WHOLE_W'(3808);

    typedef struct packed {
        logic step;         // take the input character and advance the parser
        logic div_start;    // launch the shared divider
        logic write_whole;  // store four times the quotient as the new whole-note time
        logic load_out;     // move the finished note into the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;     // the character on the input calls for a division
        logic need_emit;    // the character on the input completes a result
        logic job_note;     // the division in flight belongs to a note
        logic div_done;     // the divider has finished
        logic out_free;     // the output register can take a beat
    } dp_stat_t;

endpackage

[hw/rtl/rtn_div.sv]
// ----------------------------------------------------------------------------
// rtn_div
// Restoring divider, one quotient bit per cycle. Used for the whole-note time
// and for each note's duration.
// ----------------------------------------------------------------------------
module rtn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rtn_pkg::DVD_W-1:0]   dividend,
    input  logic [rtn_pkg::DVS_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [rtn_pkg::DVD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(rtn_pkg::DVD_W + 1);

    logic [rtn_pkg::DVD_W-1:0] quo_reg;
    logic [rtn_pkg::DVS_W-1:0] rem_reg;
    logic [rtn_pkg::DVS_W-1:0] dsr_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [rtn_pkg::DVS_W:0]   trial;
    logic [rtn_pkg::DVS_W:0]   diff;
    logic                      qbit;
    logic [rtn_pkg::DVS_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[rtn_pkg::DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        qbit     = (trial >= {1'b0, dsr_reg});
        // The remainder stays below the divisor, so it fits the divisor width.
        rem_next = qbit ? diff[rtn_pkg::DVS_W-1:0] : trial[rtn_pkg::DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(rtn_pkg::DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[rtn_pkg::DVD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/rtn_dp.sv]
// ----------------------------------------------------------------------------
// rtn_dp
// Parser datapath: character decoding, header and note state, the divider
// and the output register. Apart from octave shift writes, it acts only on
// commands from the controller.
module rtn_dp #(
    parameter int TABLE_NOTES = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rtn_pkg::ctrl_cmd_t             cmd,
    output rtn_pkg::dp_stat_t              stat,
    input  logic [rtn_pkg::CHAR_W-1:0]     char_code,
    input  logic                           song_start,
    input  logic                           cfg_we,
    input  logic [rtn_pkg::SHIFT_W-1:0]    cfg_shift,
    output logic [rtn_pkg::SHIFT_W-1:0]    octave_shift,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rtn_pkg::PITCH_W-1:0]    pitch_index,
    output logic [rtn_pkg::OCT_W-1:0]      octave_used,
    output logic [rtn_pkg::DUR_W-1:0]      duration_ms,
    output logic                           is_rest,
    output logic                           out_of_range,
    output logic                           end_of_song
);

    typedef enum logic [3:0] {
        PH_NAME   = 4'd0,
        PH_HD     = 4'd1,
        PH_DEQ    = 4'd2,
        PH_DNUM   = 4'd3,
        PH_HO     = 4'd4,
        PH_OEQ    = 4'd5,
        PH_ODIG   = 4'd6,
        PH_OSKIP  = 4'd7,
        PH_HB     = 4'd8,
        PH_BEQ    = 4'd9,
        PH_BNUM   = 4'd10,
        PH_NDUR   = 4'd11,
        PH_NSHARP = 4'd12,
        PH_NDOT   = 4'd13,
        PH_NOCT   = 4'd14,
        PH_NCOMMA = 4'd15
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;

    // Index n of the table corresponds to octave*12 + semitone = n + 48.
    localparam logic [8:0] IDX_BASE = 9'd48;
    localparam logic [8:0] IDX_LO   = 9'd49;
    localparam logic [8:0] IDX_HI   = 9'(48 + TABLE_NOTES);

    localparam int NUM_W = rtn_pkg::NUM_W;

    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] a,
                                                   input logic [7:0] ch);
        logic [16:0] v;
        begin
            v = 17'(a) * 17'd10 + 17'(ch - CH_0);
            add_digit = (v > 17'(rtn_pkg::NUM_MAX)) ? rtn_pkg::NUM_MAX : v[NUM_W-1:0];
        end
    endfunction

    function automatic logic [3:0] letter_semitone(input logic [7:0] ch);
        begin
            case (ch)
                CH_C:    letter_semitone = 4'd1;
                CH_D:    letter_semitone = 4'd3;
                CH_E:    letter_semitone = 4'd5;
                CH_F:    letter_semitone = 4'd6;
                CH_G:    letter_semitone = 4'd8;
                CH_A:    letter_semitone = 4'd10;
                CH_B:    letter_semitone = 4'd12;
                default: letter_semitone = 4'd0;
            endcase
        end
    endfunction

    // Parser state
    phase_t                        phase_reg;
    logic [NUM_W-1:0]              acc_reg;
    logic [rtn_pkg::DDUR_W-1:0]    ddur_reg;
    logic [rtn_pkg::DOCT_W-1:0]    doct_reg;
    logic [NUM_W-1:0]              tempo_reg;
    logic [rtn_pkg::WHOLE_W-1:0]   whole_reg;
    logic [3:0]                    psemi_reg;
    logic                          pdot_reg;
    logic [3:0]                    poct_reg;
    logic [rtn_pkg::SHIFT_W-1:0]   shift_reg;

    // Job held while the divider runs
    logic                          job_note_reg;
    logic                          job_zero_reg;
    logic                          job_dot_reg;
    logic                          job_eos_reg;
    logic                          job_rest_reg;
    logic                          job_oor_reg;
    logic [rtn_pkg::PITCH_W-1:0]   job_pitch_reg;
    logic [rtn_pkg::OCT_W-1:0]     job_oct_reg;

    // Output register
    logic                          out_valid_reg;
    logic [rtn_pkg::PITCH_W-1:0]   pitch_reg;
    logic [rtn_pkg::OCT_W-1:0]     oct_reg;
    logic [rtn_pkg::DUR_W-1:0]     dur_reg;
    logic                          rest_reg;
    logic                          oor_reg;
    logic                          eos_reg;

    // Step decode
    phase_t                        ph;
    phase_t                        phase_next;
    logic [NUM_W-1:0]              acc;
    logic [NUM_W-1:0]              acc_next;
    logic [rtn_pkg::DDUR_W-1:0]    ddur_next;
    logic [rtn_pkg::DOCT_W-1:0]    doct_next;
    logic [NUM_W-1:0]              tempo_next;
    logic [3:0]                    ps;
    logic [3:0]                    psemi_next;
    logic                          pd;
    logic                          pdot_next;
    logic [3:0]                    po;
    logic [3:0]                    poct_next;
    logic                          is_dig;
    logic                          emit_note;
    logic                          emit_zero;
    logic                          whole_req;
    logic                          nc_en;
    logic [NUM_W-1:0]              nc_base;

    // Note fields
    logic [NUM_W-1:0]              div_sel;
    logic [4:0]                    oct5;
    logic [7:0]                    idx_val;
    logic                          idx_ok;
    logic                          rest_now;

    // Divider
    logic [rtn_pkg::DVD_W-1:0]     dvd;
    logic [rtn_pkg::DVS_W-1:0]     dvs;
    logic                          div_busy;
    logic                          div_done;
    logic [rtn_pkg::DVD_W-1:0]     quo;
    logic [rtn_pkg::DUR_W-1:0]     dur_calc;

    always_comb
    begin
        ph  = song_start ? PH_NAME : phase_reg;
        acc = song_start ? '0 : acc_reg;
        ps  = song_start ? 4'd0 : psemi_reg;
        pd  = song_start ? 1'b0 : pdot_reg;
        po  = song_start ? 4'd0 : poct_reg;

        is_dig     = (char_code inside {[CH_0:CH_9]});
        phase_next = ph;
        acc_next   = acc;
        ddur_next  = ddur_reg;
        doct_next  = doct_reg;
        tempo_next = tempo_reg;
        psemi_next = ps;
        pdot_next  = pd;
        poct_next  = po;
        emit_note  = 1'b0;
        emit_zero  = 1'b0;
        whole_req  = 1'b0;
        nc_en      = 1'b0;
        nc_base    = acc;

        if (char_code == CH_NUL)
        begin
            if (ph >= PH_NSHARP)
            begin
                emit_note = 1'b1;
            end
            else
            begin
                emit_zero = 1'b1;
            end
            phase_next = PH_NAME;
            acc_next   = '0;
        end
        else
        begin
            case (ph)
                PH_NAME:
                begin
                    if (char_code == CH_COLON)
                    begin
                        phase_next = PH_HD;
                    end
                end
                PH_HD, PH_HO, PH_HB:
                begin
                    // A missing field falls through to the next one, and
                    // after the tempo field to the first note.
                    if (ph == PH_HD && char_code == CH_D)
                    begin
                        phase_next = PH_DEQ;
                    end
                    else if (ph != PH_HB && char_code == CH_O)
                    begin
                        phase_next = PH_OEQ;
                    end
                    else if (char_code == CH_B)
                    begin
                        phase_next = PH_BEQ;
                    end
                    else
                    begin
                        whole_req  = 1'b1;
                        phase_next = PH_NDUR;
                        nc_en      = 1'b1;
                        nc_base    = '0;
                    end
                end
                PH_DEQ:
                begin
                    acc_next   = '0;
                    phase_next = PH_DNUM;
                end
                PH_DNUM:
                begin
                    if (is_dig)
                    begin
                        acc_next = add_digit(acc, char_code);
                    end
                    else
                    begin
                        if (acc != '0)
                        begin
                            ddur_next = (acc > NUM_W'(rtn_pkg::DDUR_MAX)) ?
                                        rtn_pkg::DDUR_MAX : acc[rtn_pkg::DDUR_W-1:0];
                        end
                        acc_next   = '0;
                        phase_next = PH_HO;
                    end
                end
                PH_OEQ:
                begin
                    phase_next = PH_ODIG;
                end
                PH_ODIG:
                begin
                    if (char_code inside {[CH_3:CH_7]})
                    begin
                        doct_next = char_code[rtn_pkg::DOCT_W-1:0];
                    end
                    phase_next = PH_OSKIP;
                end
                PH_OSKIP:
                begin
                    phase_next = PH_HB;
                end
                PH_BEQ:
                begin
                    acc_next   = '0;
                    phase_next = PH_BNUM;
                end
                PH_BNUM:
                begin
                    if (is_dig)
                    begin
                        acc_next = add_digit(acc, char_code);
                    end
                    else
                    begin
                        tempo_next = acc;
                        whole_req  = 1'b1;
                        acc_next   = '0;
                        phase_next = PH_NDUR;
                    end
                end
                PH_NDUR:
                begin
                    nc_en   = 1'b1;
                    nc_base = acc;
                end
                default:
                begin
                    if (char_code == CH_COMMA)
                    begin
                        emit_note  = 1'b1;
                        acc_next   = '0;
                        phase_next = PH_NDUR;
                    end
                    else if (char_code == CH_HASH && ph == PH_NSHARP)
                    begin
                        if (ps != 4'd0)
                        begin
                            psemi_next = ps + 4'd1;
                        end
                        phase_next = PH_NDOT;
                    end
                    else if (char_code == CH_DOT && ph <= PH_NDOT)
                    begin
                        pdot_next  = 1'b1;
                        phase_next = PH_NOCT;
                    end
                    else if (is_dig && ph <= PH_NOCT)
                    begin
                        poct_next  = 4'(char_code - CH_0) + 4'd1;
                        phase_next = PH_NCOMMA;
                    end
                    else
                    begin
                        // The character cannot extend the note: report it and
                        // start the next note with this character.
                        emit_note  = 1'b1;
                        phase_next = PH_NDUR;
                        nc_en      = 1'b1;
                        nc_base    = '0;
                    end
                end
            endcase
        end

        if (nc_en)
        begin
            if (is_dig)
            begin
                acc_next = add_digit(nc_base, char_code);
            end
            else
            begin
                acc_next   = nc_base;
                psemi_next = letter_semitone(char_code);
                pdot_next  = 1'b0;
                poct_next  = 4'd0;
                phase_next = PH_NSHARP;
            end
        end
    end

    // Fields of the note being reported, taken from the state before the step.
    always_comb
    begin
        div_sel = (acc != '0) ? acc : NUM_W'(ddur_reg);
        if (div_sel == '0)
        begin
            div_sel = NUM_W'(1);
        end
        oct5     = ((po != 4'd0) ? {1'b0, po - 4'd1} : 5'(doct_reg)) + 5'(shift_reg);
        idx_val  = 8'(oct5) * 8'd12 + 8'(ps);
        idx_ok   = (9'(idx_val) >= IDX_LO) && (9'(idx_val) <= IDX_HI);
        rest_now = (ps == 4'd0);

        if (whole_req)
        begin
            dvd = rtn_pkg::MS_PER_MIN;
            dvs = (tempo_next == '0) ? rtn_pkg::DVS_W'(1) : tempo_next;
        end
        else
        begin
            dvd = whole_reg;
            dvs = div_sel;
        end
    end

    rtn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        if (job_zero_reg)
        begin
            dur_calc = '0;
        end
        else if (job_dot_reg)
        begin
            dur_calc = rtn_pkg::DUR_W'(quo) + rtn_pkg::DUR_W'(quo[rtn_pkg::DVD_W-1:1]);
        end
        else
        begin
            dur_calc = rtn_pkg::DUR_W'(quo);
        end
    end

    always_comb
    begin
        stat.need_div  = emit_note || whole_req;
        stat.need_emit = emit_note || emit_zero;
        stat.job_note  = job_note_reg;
        stat.div_done  = div_done;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NAME;
            acc_reg       <= '0;
            ddur_reg      <= rtn_pkg::DDUR_RESET;
            doct_reg      <= rtn_pkg::DOCT_RESET;
            tempo_reg     <= rtn_pkg::TEMPO_RESET;
            whole_reg     <= rtn_pkg::WHOLE_RESET;
            psemi_reg     <= 4'd0;
            pdot_reg      <= 1'b0;
            poct_reg      <= 4'd0;
            shift_reg     <= '0;
            job_note_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                shift_reg <= cfg_shift;
            end
            if (cmd.step)
            begin
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                ddur_reg     <= ddur_next;
                doct_reg     <= doct_next;
                tempo_reg    <= tempo_next;
                psemi_reg    <= psemi_next;
                pdot_reg     <= pdot_next;
                poct_reg     <= poct_next;
                job_note_reg <= emit_note;
            end
            if (cmd.write_whole)
            begin
                whole_reg <= {quo[rtn_pkg::WHOLE_W-3:0], 2'b00};
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            job_zero_reg  <= emit_zero;
            job_dot_reg   <= pd;
            job_eos_reg   <= (char_code == CH_NUL);
            job_rest_reg  <= emit_note && rest_now;
            job_oor_reg   <= emit_note && !rest_now && !idx_ok;
            job_pitch_reg <= (emit_note && !rest_now && idx_ok) ?
                             rtn_pkg::PITCH_W'(9'(idx_val) - IDX_BASE) : '0;
            job_oct_reg   <= !emit_note ? '0 :
                             (oct5 > 5'd15) ? 4'd15 : oct5[rtn_pkg::OCT_W-1:0];
        end
        if (cmd.load_out)
        begin
            pitch_reg <= job_pitch_reg;
            oct_reg   <= job_oct_reg;
            dur_reg   <= dur_calc;
            rest_reg  <= job_rest_reg;
            oor_reg   <= job_oor_reg;
            eos_reg   <= job_eos_reg;
        end
    end

    assign octave_shift = shift_reg;
    assign out_valid    = out_valid_reg;
    assign pitch_index  = pitch_reg;
    assign octave_used  = oct_reg;
    assign duration_ms  = dur_reg;
    assign is_rest      = rest_reg;
    assign out_of_range = oor_reg;
    assign end_of_song  = eos_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while still busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten before its beat was taken");

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> !div_done)
        else $error("divider completion lasted more than one cycle");

    a_whole_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_whole && cmd.load_out))
        else $error("tempo result and note result taken together");

endmodule

[hw/rtl/rtn_ctrl.sv]
// ----------------------------------------------------------------------------
// rtn_ctrl
// Controller of the note parser: takes one character at a time, waits for the
// divider and hands each finished note to the output register.
// ----------------------------------------------------------------------------
module rtn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  rtn_pkg::dp_stat_t    stat,
    output rtn_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd.step        = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.write_whole = 1'b0;
        cmd.load_out    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step      = 1'b1;
                    cmd.div_start = stat.need_div;
                    if (stat.need_div)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (stat.need_emit)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.job_note)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.write_whole = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

[hw/rtl/ringtone_text_note_parser_unit.sv]
// Flow: a note beat runs the divider on the whole-note time, and the note is moved
// into the output register once the divider is done and the register is free.
// Throughput: one beat per cycle while no division or result is due; a note beat,
// a closing tempo beat or a bare terminator holds the input until it is handled.
// Reset: asynchronous, active low; parsing restarts at the song name with duration
// 4, octave 6 and tempo 63, and the octave shift clears.
// ----------------------------------------------------------------------------
// ringtone_text_note_parser_unit
// Ring-tone text parser: reads the song header and notes character by
// character and reports each note's table index, octave and duration.
// ----------------------------------------------------------------------------
module ringtone_text_note_parser_unit #(
    parameter int TABLE_NOTES = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rtn_pkg::CHAR_W-1:0]    char_code,
    input  logic                          song_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rtn_pkg::PITCH_W-1:0]   pitch_index,
    output logic [rtn_pkg::OCT_W-1:0]     octave_used,
    output logic [rtn_pkg::DUR_W-1:0]     duration_ms,
    output logic                          is_rest,
    output logic                          out_of_range,
    output logic                          end_of_song
);

    rtn_pkg::ctrl_cmd_t           cmd;
    rtn_pkg::dp_stat_t            stat;
    logic                         cfg_we;
    logic [rtn_pkg::SHIFT_W-1:0]  shift_q;

    // The shift register answers wherever paddr[2] is low; other words read as zero.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(shift_q) : 32'd0;

    rtn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtn_dp #(
        .TABLE_NOTES (TABLE_NOTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .char_code    (char_code),
        .song_start   (song_start),
        .cfg_we       (cfg_we),
        .cfg_shift    (pwdata[rtn_pkg::SHIFT_W-1:0]),
        .octave_shift (shift_q),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pitch_index  (pitch_index),
        .octave_used  (octave_used),
        .duration_ms  (duration_ms),
        .is_rest      (is_rest),
        .out_of_range (out_of_range),
        .end_of_song  (end_of_song)
    );

endmodule

[tb/sv/tb_ringtone_text_note_parser_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ringtone_text_note_parser_unit
// Streams ring-tone text into the parser and checks every reported note
// against a parser kept inside this bench. The text mixes short directed
// songs, long random songs with random headers and notes, and raw noise.
// Both channels idle at random. A long receiver hold-off fills the block,
// and the octave shift register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_ringtone_text_note_parser_unit;

    localparam int TABLE_NOTES = 48;
    localparam int SETTLE_CYCLES = 30;
    localparam logic [2:0] REG_OCT_SHIFT = 3'd0;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_SHARP = "#";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_3     = "3";
    localparam logic [7:0] CH_4     = "4";
    localparam logic [7:0] CH_7     = "7";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_MAX   = 8'hFF;

    typedef enum logic [3:0] {
        PH_NAME, PH_HDR_D, PH_D_EQ, PH_D_NUM, PH_HDR_O, PH_O_EQ, PH_O_DIGIT, PH_O_SKIP,
        PH_HDR_B, PH_B_EQ, PH_B_NUM, PH_NOTE_LEN, PH_NOTE_SHARP, PH_NOTE_DOT,
        PH_NOTE_OCT, PH_NOTE_END
    } parse_phase_t;

    typedef struct packed {
        logic [rtn_pkg::PITCH_W-1:0] pitch;
        logic [rtn_pkg::OCT_W-1:0]   octave;
        logic [rtn_pkg::DUR_W-1:0]   len_ms;
        logic                        rest;
        logic                        oor;
        logic                        eos;
    } note_t;

    typedef struct packed {
        logic [rtn_pkg::CHAR_W-1:0] ch;
        logic                       start;
    } char_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [2:0]                    paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [rtn_pkg::CHAR_W-1:0]    char_code = '0;
    logic                          song_start = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rtn_pkg::PITCH_W-1:0]   pitch_index;
    logic [rtn_pkg::OCT_W-1:0]     octave_used;
    logic [rtn_pkg::DUR_W-1:0]     duration_ms;
    logic                          is_rest;
    logic                          out_of_range;
    logic                          end_of_song;

    // Parser state as the bench sees it.
    parse_phase_t                  ph;
    logic [rtn_pkg::NUM_W-1:0]     num_acc;
    logic [rtn_pkg::DDUR_W-1:0]    dflt_len;
    logic [rtn_pkg::DOCT_W-1:0]    dflt_oct;
    logic [rtn_pkg::NUM_W-1:0]     bpm;
    logic [rtn_pkg::WHOLE_W-1:0]   whole_ms;
    logic [3:0]                    note_semi;
    logic                          note_dot;
    logic [3:0]                    note_oct;
    logic [rtn_pkg::SHIFT_W-1:0]   oct_shift;

    note_t                expected_notes[$];
    char_beat_t           song_text[$];
    int                   chars_sent = 0;
    int                   error_count = 0;
    int                   hold_left = 0;
    bit                   quiet_mode = 1'b0;

    ringtone_text_note_parser_unit #(
        .TABLE_NOTES(TABLE_NOTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .char_code(char_code),
        .song_start(song_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pitch_index(pitch_index),
        .octave_used(octave_used),
        .duration_ms(duration_ms),
        .is_rest(is_rest),
        .out_of_range(out_of_range),
        .end_of_song(end_of_song)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4ms;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Note predictor
    // ------------------------------------------------------------------------
    function automatic bit is_num_char(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic void push_digit(logic [7:0] c);
        int v;
        v = int'(num_acc) * 10 + int'(c - CH_0);
        num_acc = (v > int'(rtn_pkg::NUM_MAX)) ? rtn_pkg::NUM_MAX : rtn_pkg::NUM_W'(v);
    endfunction

    function automatic void update_whole_note();
        int b;
        b = (bpm == 0) ? 1 : int'(bpm);
        whole_ms = rtn_pkg::WHOLE_W'((int'(rtn_pkg::MS_PER_MIN) / b) * 4);
    endfunction

    function automatic logic [3:0] semitone_of(logic [7:0] c);
        case (c)
            "c": return 4'd1;
            "d": return 4'd3;
            "e": return 4'd5;
            "f": return 4'd6;
            "g": return 4'd8;
            "a": return 4'd10;
            "b": return 4'd12;
            default: return 4'd0;
        endcase
    endfunction

    function automatic void start_note(logic [7:0] c);
        if (is_num_char(c))
        begin
            push_digit(c);
            return;
        end
        note_semi = semitone_of(c);
        note_dot = 1'b0;
        note_oct = '0;
        ph = PH_NOTE_SHARP;
    endfunction

    function automatic void try_tempo_field(logic [7:0] c);
        if (c == "b")
        begin
            ph = PH_B_EQ;
            return;
        end
        update_whole_note();
        num_acc = '0;
        ph = PH_NOTE_LEN;
        start_note(c);
    endfunction

    function automatic void try_octave_field(logic [7:0] c);
        if (c == "o")
            ph = PH_O_EQ;
        else
            try_tempo_field(c);
    endfunction

    function automatic void emit_note(logic eos);
        note_t n;
        int    div;
        int    len;
        int    o;
        int    idx;
        n = '0;
        div = (num_acc != 0) ? int'(num_acc) : int'(dflt_len);
        if (div == 0)
            div = 1;
        len = int'(whole_ms) / div;
        if (note_dot)
            len = len + len / 2;
        o = ((note_oct != 0) ? int'(note_oct) - 1 : int'(dflt_oct)) + int'(oct_shift);
        if (note_semi == 0)
            n.rest = 1'b1;
        else
        begin
            idx = o * 12 - 48 + int'(note_semi);
            if (idx < 1 || idx > TABLE_NOTES)
                n.oor = 1'b1;
            else
                n.pitch = rtn_pkg::PITCH_W'(idx);
        end
        n.octave = (o > 15) ? 4'd15 : rtn_pkg::OCT_W'(o);
        n.len_ms = rtn_pkg::DUR_W'(len);
        n.eos = eos;
        expected_notes.push_back(n);
    endfunction

    function automatic void track_char(logic [7:0] c, logic start);
        note_t blank;
        if (start)
        begin
            ph = PH_NAME;
            num_acc = '0;
            note_semi = '0;
            note_dot = 1'b0;
            note_oct = '0;
        end
        if (c == CH_NUL)
        begin
            if (ph >= PH_NOTE_SHARP)
                emit_note(1'b1);
            else
            begin
                blank = '0;
                blank.eos = 1'b1;
                expected_notes.push_back(blank);
            end
            ph = PH_NAME;
            num_acc = '0;
            return;
        end
        case (ph)
            PH_NAME:
                if (c == CH_COLON)
                    ph = PH_HDR_D;
            PH_HDR_D:
                if (c == "d")
                    ph = PH_D_EQ;
                else
                    try_octave_field(c);
            PH_D_EQ:
            begin
                num_acc = '0;
                ph = PH_D_NUM;
            end
            PH_D_NUM:
                if (is_num_char(c))
                    push_digit(c);
                else
                begin
                    if (num_acc > 0)
                        dflt_len = (num_acc > rtn_pkg::NUM_W'(rtn_pkg::DDUR_MAX)) ?
                                   rtn_pkg::DDUR_MAX : rtn_pkg::DDUR_W'(num_acc);
                    num_acc = '0;
                    ph = PH_HDR_O;
                end
            PH_HDR_O:
                try_octave_field(c);
            PH_O_EQ:
                ph = PH_O_DIGIT;
            PH_O_DIGIT:
            begin
                if (c >= CH_3 && c <= CH_7)
                    dflt_oct = rtn_pkg::DOCT_W'(c - CH_0);
                ph = PH_O_SKIP;
            end
            PH_O_SKIP:
                ph = PH_HDR_B;
            PH_HDR_B:
                try_tempo_field(c);
            PH_B_EQ:
            begin
                num_acc = '0;
                ph = PH_B_NUM;
            end
            PH_B_NUM:
                if (is_num_char(c))
                    push_digit(c);
                else
                begin
                    bpm = num_acc;
                    update_whole_note();
                    num_acc = '0;
                    ph = PH_NOTE_LEN;
                end
            PH_NOTE_LEN:
                start_note(c);
            default:
                if (c == CH_COMMA)
                begin
                    emit_note(1'b0);
                    num_acc = '0;
                    ph = PH_NOTE_LEN;
                end
                else if (c == CH_SHARP && ph == PH_NOTE_SHARP)
                begin
                    // A sharp on a rest is swallowed; on b it rolls into the next C.
                    if (note_semi != 0)
                        note_semi = note_semi + 4'd1;
                    ph = PH_NOTE_DOT;
                end
                else if (c == CH_DOT && ph <= PH_NOTE_DOT)
                begin
                    note_dot = 1'b1;
                    ph = PH_NOTE_OCT;
                end
                else if (is_num_char(c) && ph <= PH_NOTE_OCT)
                begin
                    note_oct = 4'(c - CH_0 + 8'd1);
                    ph = PH_NOTE_END;
                end
                else
                begin
                    emit_note(1'b0);
                    num_acc = '0;
                    ph = PH_NOTE_LEN;
                    start_note(c);
                end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= quiet_mode ? 1'b0 : ($urandom_range(0, 99) < 21);
    end

    task automatic report_field(input string field, input int exp_val, input int act_val);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
    endtask

    always @(posedge clk)
    begin
        note_t exp_note;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_notes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected note: expected none, actual pitch %0d len %0d",
                         $time, pitch_index, duration_ms);
            end
            else
            begin
                exp_note = expected_notes.pop_front();
                if (pitch_index !== exp_note.pitch)
                    report_field("pitch_index", exp_note.pitch, pitch_index);
                if (octave_used !== exp_note.octave)
                    report_field("octave_used", exp_note.octave, octave_used);
                if (duration_ms !== exp_note.len_ms)
                    report_field("duration_ms", exp_note.len_ms, duration_ms);
                if (is_rest !== exp_note.rest)
                    report_field("is_rest", exp_note.rest, is_rest);
                if (out_of_range !== exp_note.oor)
                    report_field("out_of_range", exp_note.oor, out_of_range);
                if (end_of_song !== exp_note.eos)
                    report_field("end_of_song", exp_note.eos, end_of_song);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Text side
    // ------------------------------------------------------------------------
    // Called and returning at a falling edge; valid stays high into the next call.
    task automatic send_char(input logic [7:0] c, input logic start);
        int gap;
        if (!quiet_mode && $urandom_range(0, 99) < 21)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 4);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        char_code = c;
        song_start = start;
        do
            @(posedge clk);
        while (in_stall);
        track_char(c, start);
        chars_sent++;
        @(negedge clk);
    endtask

    function automatic void push_beat(logic [7:0] c, logic start);
        char_beat_t b;
        b.ch = c;
        b.start = start;
        song_text.push_back(b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], 1'b0);
    endfunction

    task automatic send_text();
        foreach (song_text[i])
            send_char(song_text[i].ch, song_text[i].start);
        song_text.delete();
    endtask

    // Lets every expected note arrive, then covers a division still in flight.
    task automatic wait_notes_drained();
        in_valid = 1'b0;
        while (expected_notes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_octave_shift(input logic [rtn_pkg::SHIFT_W-1:0] val);
        wait_notes_drained();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_OCT_SHIFT;
        pwdata = 32'(val);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        oct_shift = val;
        @(negedge clk);
        // Back-to-back read of the same register.
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(val))
        begin
            error_count++;
            $display("%0t: octave_shift readback: expected %0d, actual %0d", $time, val,
                     prdata);
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic int pick_count();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return $urandom_range(10000, 99999);
            2: return $urandom_range(256, 9999);
            default: return 1 << $urandom_range(0, 5);
        endcase
    endfunction

    function automatic int pick_tempo();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(1000, 99999);
            default: return $urandom_range(25, 300);
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        string letters;
        letters = "cdefgab";
        case ($urandom_range(0, 15))
            0, 1: return "p";
            2: return 8'($urandom_range(1, CH_MAX));
            default: return letters[$urandom_range(0, 6)];
        endcase
    endfunction

    // Builds one random song; now and then raw noise or a song without terminator.
    function automatic void build_song(int max_notes);
        int n_notes;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(4, 20))
                push_beat(8'($urandom_range(0, CH_MAX)), $urandom_range(0, 7) == 0);
            return;
        end
        repeat ($urandom_range(0, 3))
            push_beat(8'($urandom_range(CH_UP_A, CH_UP_Z)), 1'b0);
        push_beat(CH_COLON, 1'b0);
        song_text[0].start = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0)
        begin
            push_text("d=");
            if ($urandom_range(0, 7) != 0)
                push_text($sformatf("%0d", pick_count()));
            push_beat(CH_COMMA, 1'b0);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            push_text("o=");
            push_beat(($urandom_range(0, 7) == 0) ? 8'(CH_0 + $urandom_range(0, 9))
                                                  : 8'(CH_3 + $urandom_range(0, 4)), 1'b0);
            push_beat(CH_COMMA, 1'b0);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            push_text("b=");
            push_text($sformatf("%0d", pick_tempo()));
            push_beat(($urandom_range(0, 1) != 0) ? CH_COLON : CH_COMMA, 1'b0);
        end
        n_notes = $urandom_range(1, max_notes);
        for (int k = 0; k < n_notes; k++)
        begin
            if ($urandom_range(0, 1) != 0)
                push_text($sformatf("%0d", pick_count()));
            push_beat(pick_letter(), 1'b0);
            if ($urandom_range(0, 3) == 0)
                push_beat(CH_SHARP, 1'b0);
            if ($urandom_range(0, 3) == 0)
                push_beat(CH_DOT, 1'b0);
            if ($urandom_range(0, 1) != 0)
                push_beat(($urandom_range(0, 1) != 0) ? 8'(CH_4 + $urandom_range(0, 3))
                                                      : 8'(CH_0 + $urandom_range(0, 9)), 1'b0);
            if (k != n_notes - 1 && $urandom_range(0, 9) != 0)
                push_beat(CH_COMMA, 1'b0);
        end
        if ($urandom_range(0, 7) != 0)
            push_beat(CH_NUL, 1'b0);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Zero d= and zero tempo, b sharp with dot and a high octave, sharp rest,
    // terminator with a note pending.
    task automatic test_header_corners();
        set_octave_shift(3'd0);
        push_text(":d=0,b=0:b#.9,p#");
        push_beat(CH_NUL, 1'b0);
        send_text();
    endtask

    // Missing header, saturating duration, a restart dropping a pending note,
    // and a bare terminator.
    task automatic test_shift_and_restart();
        set_octave_shift(3'd4);
        push_text(":99999a3,g");
        push_beat(CH_COLON, 1'b1);
        push_text("c");
        push_beat(CH_NUL, 1'b0);
        push_beat(CH_NUL, 1'b0);
        send_text();
    endtask

    // The receiver holds off while a long song keeps coming, so the input stalls.
    task automatic test_output_hold_off();
        set_octave_shift(3'd2);
        quiet_mode = 1'b1;
        @(posedge clk);
        hold_left = 400;
        @(negedge clk);
        push_text(":d=8,o=5,b=140:");
        repeat (30)
        begin
            push_beat(pick_letter(), 1'b0);
            push_beat(CH_COMMA, 1'b0);
        end
        push_beat(CH_NUL, 1'b0);
        send_text();
        wait_notes_drained();
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_songs(input logic [rtn_pkg::SHIFT_W-1:0] shift,
                                     input bit quiet, input int beats);
        int stop_at;
        set_octave_shift(shift);
        quiet_mode = quiet;
        stop_at = chars_sent + beats;
        while (chars_sent < stop_at)
        begin
            build_song(12);
            send_text();
        end
        wait_notes_drained();
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        ph = PH_NAME;
        num_acc = '0;
        dflt_len = rtn_pkg::DDUR_RESET;
        dflt_oct = rtn_pkg::DOCT_RESET;
        bpm = rtn_pkg::TEMPO_RESET;
        whole_ms = rtn_pkg::WHOLE_RESET;
        note_semi = '0;
        note_dot = 1'b0;
        note_oct = '0;
        oct_shift = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_header_corners();
        test_shift_and_restart();
        test_output_hold_off();
        test_random_songs(3'd0, 1'b0, 300);
        test_random_songs(3'd4, 1'b0, 300);
        test_random_songs(3'($urandom_range(0, 4)), 1'b1, 300);
        test_random_songs(3'($urandom_range(0, 4)), 1'b0, 300);

        wait_notes_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
